// ===== rtl/core/rks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rks_pkg;

	// Reply length limit and counter width (counter must hold MAX_LEN itself)
	localparam int MAX_LEN = 4096;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int SCORE_W = 14;
	localparam int FLAG_W  = 4;
	localparam int HIST_W  = 48;
	localparam int WIN_W   = 56;

	// Keyword flag bit positions
	localparam int FLAG_CMD     = 0;
	localparam int FLAG_MYCALL  = 1;
	localparam int FLAG_TXDELAY = 2;
	localparam int FLAG_KISS    = 3;

	// Keyword patterns, last byte in the low 8 bits
	localparam logic [31:0] KW_CMD_LO  = 32'h636D_643A;
	localparam logic [31:0] KW_CMD_UP  = 32'h434D_443A;
	localparam logic [47:0] KW_MYC_UP  = 48'h4D59_4341_4C4C;
	localparam logic [47:0] KW_MYC_LO  = 48'h6D79_6361_6C6C;
	localparam logic [55:0] KW_TXDELAY = 56'h54_5844_454C_4159;
	localparam logic [31:0] KW_KISS    = 32'h4B49_5353;

	// Printable range, inclusive low, exclusive high
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7F;

	// Score weights and length thresholds
	localparam logic [SCORE_W-1:0] W_CMD      = SCORE_W'(200);
	localparam logic [SCORE_W-1:0] W_MYCALL   = SCORE_W'(120);
	localparam logic [SCORE_W-1:0] W_TXDELAY  = SCORE_W'(80);
	localparam logic [SCORE_W-1:0] W_KISS     = SCORE_W'(40);
	localparam logic [SCORE_W-1:0] W_LONG     = SCORE_W'(60);
	localparam logic [SCORE_W-1:0] W_MID      = SCORE_W'(20);
	localparam logic [SCORE_W-1:0] W_SHORT    = SCORE_W'(10);
	localparam logic [CNT_W-1:0]   LEN_LONG   = CNT_W'(40);
	localparam logic [CNT_W-1:0]   LEN_MID    = CNT_W'(15);
	localparam logic [CNT_W-1:0]   LEN_SHORT  = CNT_W'(12);
	localparam logic [CNT_W-1:0]   LEN_MAX    = CNT_W'(MAX_LEN);

	// Running reply state
	typedef struct packed {
		logic [HIST_W-1:0] hist;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  printable;
		logic [FLAG_W-1:0] flags;
	} rks_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/reply_keyword_scorer_unit.sv =====
// An item is held in the input register before it reaches the state/result logic;
//   a result is loaded into the result register when its end-marked item advances from the input register.
// Throughput: one item per cycle unless a result stalls; set by the single input register and result register.
// An end-marked item waits in the input register only while an undelivered result stalls.
// Reset (arst_n low, asynchronous): valid flags drop and the running reply state clears.
`timescale 1ns / 1ps
`default_nettype none

module reply_keyword_scorer_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                has_byte,
	input  wire logic                                last,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [rks_pkg::SCORE_W-1:0]       score,
	output logic [rks_pkg::CNT_W-1:0]                reply_length,
	output logic [rks_pkg::CNT_W-1:0]                printable_count,
	output logic [rks_pkg::FLAG_W-1:0]               keyword_flags
);

	logic                                valid_s1;
	logic [7:0]                          data_s1;
	logic                                has_s1;
	logic                                last_s1;
	logic                                adv_s1;
	rks_pkg::rks_state_t                 state_q;
	rks_pkg::rks_state_t                 state_nxt;
	logic signed [rks_pkg::SCORE_W-1:0] score_nxt;
	logic                                out_valid_q;
	logic signed [rks_pkg::SCORE_W-1:0] score_q;
	logic [rks_pkg::CNT_W-1:0]           length_q;
	logic [rks_pkg::CNT_W-1:0]           print_q;
	logic [rks_pkg::FLAG_W-1:0]          flags_q;

	// Advance the staged item unless it ends a reply and the result slot is full
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			has_s1  <= has_byte;
			last_s1 <= last;
		end
	end

	rks_byte_update u_update (
		.cur       (state_q),
		.data_byte (data_s1),
		.has_byte  (has_s1),
		.nxt       (state_nxt)
	);

	rks_score u_score (
		.st    (state_nxt),
		.score (score_nxt)
	);

	// Running state; clear after each end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			score_q  <= score_nxt;
			length_q <= state_nxt.count;
			print_q  <= state_nxt.printable;
			flags_q  <= state_nxt.flags;
		end
	end

	assign out_valid       = out_valid_q;
	assign score           = score_q;
	assign reply_length    = length_q;
	assign printable_count = print_q;
	assign keyword_flags   = flags_q;

endmodule

`default_nettype wire

// ===== rtl/core/rks_byte_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rks_byte_update (
	input  wire rks_pkg::rks_state_t cur,
	input  wire logic [7:0]          data_byte,
	input  wire logic                has_byte,
	output rks_pkg::rks_state_t      nxt
);

	logic                     take;
	logic [rks_pkg::WIN_W-1:0] win;
	logic [rks_pkg::FLAG_W-1:0] hit;

	// Take the byte only while the reply is below the length limit
	assign take = has_byte && (cur.count < rks_pkg::LEN_MAX);
	assign win  = {cur.hist, data_byte};

	// Match each keyword group against the window ending in the new byte
	always_comb begin
		hit = '0;
		hit[rks_pkg::FLAG_CMD] = (win[31:0] == rks_pkg::KW_CMD_LO) ||
			(win[31:0] == rks_pkg::KW_CMD_UP);
		hit[rks_pkg::FLAG_MYCALL] = (win[47:0] == rks_pkg::KW_MYC_UP) ||
			(win[47:0] == rks_pkg::KW_MYC_LO);
		hit[rks_pkg::FLAG_TXDELAY] = (win == rks_pkg::KW_TXDELAY);
		hit[rks_pkg::FLAG_KISS] = (win[31:0] == rks_pkg::KW_KISS);
	end

	// Advance counts, history and sticky flags
	always_comb begin
		nxt = cur;
		if (take) begin
			nxt.count = cur.count + 1'b1;
			if ((data_byte >= rks_pkg::PRINT_LO) && (data_byte < rks_pkg::PRINT_HI)) begin
				nxt.printable = cur.printable + 1'b1;
			end
			nxt.hist  = win[rks_pkg::HIST_W-1:0];
			nxt.flags = cur.flags | hit;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rks_score.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rks_score (
	input  wire rks_pkg::rks_state_t            st,
	output logic signed [rks_pkg::SCORE_W-1:0] score
);

	logic [rks_pkg::SCORE_W-1:0] kw_sum;
	logic [rks_pkg::SCORE_W-1:0] len_adj;
	logic [rks_pkg::SCORE_W-1:0] sum;

	// Sum the keyword weights
	always_comb begin
		kw_sum = '0;
		if (st.flags[rks_pkg::FLAG_CMD])     kw_sum = kw_sum + rks_pkg::W_CMD;
		if (st.flags[rks_pkg::FLAG_MYCALL])  kw_sum = kw_sum + rks_pkg::W_MYCALL;
		if (st.flags[rks_pkg::FLAG_TXDELAY]) kw_sum = kw_sum + rks_pkg::W_TXDELAY;
		if (st.flags[rks_pkg::FLAG_KISS])    kw_sum = kw_sum + rks_pkg::W_KISS;
	end

	// Length bonus, or penalty for a short all-printable reply
	always_comb begin
		priority if (st.count > rks_pkg::LEN_LONG) begin
			len_adj = rks_pkg::W_LONG;
		end else if (st.count > rks_pkg::LEN_MID) begin
			len_adj = rks_pkg::W_MID;
		end else if ((st.count <= rks_pkg::LEN_SHORT) && (st.printable == st.count)) begin
			len_adj = -rks_pkg::W_SHORT;
		end else begin
			len_adj = '0;
		end
	end

	// Empty reply scores zero; the sum wraps at the field width
	always_comb begin
		sum = rks_pkg::SCORE_W'(st.printable) + kw_sum + len_adj;
		if (st.count == '0) begin
			score = '0;
		end else begin
			score = $signed(sum);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rks_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rks_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [rks_pkg::SCORE_W-1:0] score,
	input wire logic [rks_pkg::CNT_W-1:0]          reply_length,
	input wire logic [rks_pkg::CNT_W-1:0]          printable_count,
	input wire logic [rks_pkg::FLAG_W-1:0]         keyword_flags
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score) && $stable(reply_length))
		else $error("stalled result changed");

	// Printable bytes never exceed the reply length
	a_print_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> printable_count <= reply_length)
		else $error("printable count above length");

	// Length saturates at the limit
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reply_length <= rks_pkg::LEN_MAX)
		else $error("length above limit");

	// Empty reply gives an all-zero result
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply_length == '0) |->
			(score == '0) && (printable_count == '0) && (keyword_flags == '0))
		else $error("empty reply not zero");

endmodule

bind reply_keyword_scorer_unit rks_checker u_rks_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.score           (score),
	.reply_length    (reply_length),
	.printable_count (printable_count),
	.keyword_flags   (keyword_flags)
);

`default_nettype wire
